@@ rtl/accelerating_pointer_repeat_assert.svh @@
// assertion macros for the pointer-repeat rtl
// each sampled on the rising edge of clk and held off while rst_n is low
`ifndef ACCELERATING_POINTER_REPEAT_ASSERT_SVH
`define ACCELERATING_POINTER_REPEAT_ASSERT_SVH

// condition holds at every edge
`define APR_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define APR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define APR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/apr_pkg.sv @@
`default_nettype none

package apr_pkg;

    // stream and register port widths
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 24;
    localparam int ADDR_W   = 5;

    // command on the input stream
    localparam logic CMD_ACTION = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // option codes
    localparam logic [3:0] OPT_UP          = 4'd1;
    localparam logic [3:0] OPT_DOWN        = 4'd2;
    localparam logic [3:0] OPT_LEFT        = 4'd3;
    localparam logic [3:0] OPT_RIGHT       = 4'd4;
    localparam logic [3:0] OPT_CLICK       = 4'd5;
    localparam logic [3:0] OPT_PRESS       = 4'd6;
    localparam logic [3:0] OPT_RELEASE     = 4'd7;
    localparam logic [3:0] OPT_RCLICK      = 4'd8;
    localparam logic [3:0] OPT_NUDGE_UP    = 4'd10;
    localparam logic [3:0] OPT_NUDGE_DOWN  = 4'd11;
    localparam logic [3:0] OPT_NUDGE_LEFT  = 4'd12;
    localparam logic [3:0] OPT_NUDGE_RIGHT = 4'd13;
    localparam logic [3:0] OPT_NUDGE_STOP  = 4'd14;

    // result kinds
    localparam logic [2:0] KIND_MOVE    = 3'd0;
    localparam logic [2:0] KIND_LCLICK  = 3'd1;
    localparam logic [2:0] KIND_RCLICK  = 3'd2;
    localparam logic [2:0] KIND_PRESS   = 3'd3;
    localparam logic [2:0] KIND_RELEASE = 3'd4;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_PHASE1_DELAY = 3'd0;
    localparam logic [2:0] REG_PHASE1_STEP  = 3'd1;
    localparam logic [2:0] REG_PHASE1_END   = 3'd2;
    localparam logic [2:0] REG_PHASE2_DELAY = 3'd3;
    localparam logic [2:0] REG_PHASE2_STEP  = 3'd4;
    localparam logic [2:0] REG_PHASE2_END   = 3'd5;
    localparam logic [2:0] REG_PHASE3_DELAY = 3'd6;
    localparam logic [2:0] REG_PHASE3_STEP  = 3'd7;

    // register reset values
    localparam logic [7:0]  PHASE1_DELAY_RST = 8'd35;
    localparam logic [7:0]  PHASE1_STEP_RST  = 8'd2;
    localparam logic [15:0] PHASE1_END_RST   = 16'd500;
    localparam logic [7:0]  PHASE2_DELAY_RST = 8'd59;
    localparam logic [7:0]  PHASE2_STEP_RST  = 8'd6;
    localparam logic [15:0] PHASE2_END_RST   = 16'd1000;
    localparam logic [7:0]  PHASE3_DELAY_RST = 8'd23;
    localparam logic [7:0]  PHASE3_STEP_RST  = 8'd6;

    // per-axis nudge direction
    typedef enum logic [1:0] {
        NUDGE_STILL = 2'd0,
        NUDGE_NEG   = 2'd1,
        NUDGE_POS   = 2'd2
    } nudge_t;

    typedef struct packed {
        logic [7:0]  phase1_delay;
        logic [7:0]  phase1_step;
        logic [15:0] phase1_end;
        logic [7:0]  phase2_delay;
        logic [7:0]  phase2_step;
        logic [15:0] phase2_end;
        logic [7:0]  phase3_delay;
        logic [7:0]  phase3_step;
    } apr_cfg_t;

    typedef struct packed {
        logic        cmd;
        logic [3:0]  option;
        logic        repeat_flag;
        logic [15:0] now_ms;
    } apr_item_t;

    typedef struct packed {
        logic [2:0]        kind;
        logic signed [8:0] dx;
        logic signed [8:0] dy;
    } apr_result_t;

    // up to two results for one request
    typedef struct packed {
        logic [1:0]  count;
        apr_result_t first;
        apr_result_t second;
    } apr_batch_t;

endpackage

`default_nettype wire

@@ rtl/apr_core.sv @@
`default_nettype none

module apr_core
    import apr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire apr_cfg_t  cfg,
    input  wire logic      fire,
    input  wire apr_item_t item,
    output apr_batch_t     batch
);

    logic [15:0] press_start_reg, press_start_next;
    logic [15:0] vert_time_reg, vert_time_next;
    logic [15:0] horz_time_reg, horz_time_next;
    logic        top_speed_reg, top_speed_next;
    nudge_t      vert_nudge_reg, vert_nudge_next;
    nudge_t      horz_nudge_reg, horz_nudge_next;

    logic [15:0] since;
    logic [15:0] vert_gap;
    logic [15:0] horz_gap;
    logic [7:0]  ev_delay;
    logic [7:0]  ev_step;
    logic        ev_top;
    logic        vert_ok;
    logic        horz_ok;
    logic [8:0]  p1_pos, p1_neg;
    logic [8:0]  ev_pos, ev_neg;
    logic        v_act, h_act;
    logic        v_emit, h_emit;
    apr_result_t v_res, h_res;

    // wrapped time differences
    assign since    = item.now_ms - press_start_reg;
    assign vert_gap = item.now_ms - vert_time_reg;
    assign horz_gap = item.now_ms - horz_time_reg;

    // speed phase from time since first press, top phase latches
    always_comb
    begin
        ev_top = 1'b0;
        if (top_speed_reg)
        begin
            ev_delay = cfg.phase3_delay;
            ev_step  = cfg.phase3_step;
            ev_top   = 1'b1;
        end
        else if (since < cfg.phase1_end)
        begin
            ev_delay = cfg.phase1_delay;
            ev_step  = cfg.phase1_step;
        end
        else if (since < cfg.phase2_end)
        begin
            ev_delay = cfg.phase2_delay;
            ev_step  = cfg.phase2_step;
        end
        else
        begin
            ev_delay = cfg.phase3_delay;
            ev_step  = cfg.phase3_step;
            ev_top   = 1'b1;
        end
    end

    assign vert_ok = vert_gap >= {8'd0, ev_delay};
    assign horz_ok = horz_gap >= {8'd0, ev_delay};

    // signed step values
    assign p1_pos = {1'b0, cfg.phase1_step};
    assign p1_neg = 9'd0 - p1_pos;
    assign ev_pos = {1'b0, ev_step};
    assign ev_neg = 9'd0 - ev_pos;

    // tick replay of the nudge directions
    assign v_act  = (vert_nudge_reg == NUDGE_NEG) || (vert_nudge_reg == NUDGE_POS);
    assign h_act  = (horz_nudge_reg == NUDGE_NEG) || (horz_nudge_reg == NUDGE_POS);
    assign v_emit = v_act && vert_ok;
    assign h_emit = h_act && horz_ok;

    always_comb
    begin
        v_res.kind = KIND_MOVE;
        v_res.dx   = 9'sd0;
        v_res.dy   = (vert_nudge_reg == NUDGE_NEG) ? $signed(ev_neg) : $signed(ev_pos);
        h_res.kind = KIND_MOVE;
        h_res.dx   = (horz_nudge_reg == NUDGE_NEG) ? $signed(ev_neg) : $signed(ev_pos);
        h_res.dy   = 9'sd0;
    end

    // request decode, state update and results
    always_comb
    begin
        press_start_next = press_start_reg;
        vert_time_next   = vert_time_reg;
        horz_time_next   = horz_time_reg;
        top_speed_next   = top_speed_reg;
        vert_nudge_next  = vert_nudge_reg;
        horz_nudge_next  = horz_nudge_reg;
        batch            = '0;

        if (item.cmd == CMD_ACTION && !item.repeat_flag)
        begin
            // first press restarts the acceleration
            press_start_next = item.now_ms;
            top_speed_next   = 1'b0;
            case (item.option)
                OPT_UP:
                begin
                    vert_time_next  = item.now_ms;
                    batch.count     = 2'd1;
                    batch.first.dy  = $signed(p1_neg);
                end
                OPT_DOWN:
                begin
                    vert_time_next  = item.now_ms;
                    batch.count     = 2'd1;
                    batch.first.dy  = $signed(p1_pos);
                end
                OPT_LEFT:
                begin
                    horz_time_next  = item.now_ms;
                    batch.count     = 2'd1;
                    batch.first.dx  = $signed(p1_neg);
                end
                OPT_RIGHT:
                begin
                    horz_time_next  = item.now_ms;
                    batch.count     = 2'd1;
                    batch.first.dx  = $signed(p1_pos);
                end
                OPT_CLICK:
                begin
                    batch.count      = 2'd1;
                    batch.first.kind = KIND_LCLICK;
                end
                OPT_RCLICK:
                begin
                    batch.count      = 2'd1;
                    batch.first.kind = KIND_RCLICK;
                end
                OPT_PRESS:
                begin
                    batch.count      = 2'd1;
                    batch.first.kind = KIND_PRESS;
                end
                OPT_RELEASE:
                begin
                    batch.count      = 2'd1;
                    batch.first.kind = KIND_RELEASE;
                end
                OPT_NUDGE_UP:
                begin
                    if (vert_nudge_reg == NUDGE_POS)
                        vert_nudge_next = NUDGE_STILL;
                    else if (vert_nudge_reg == NUDGE_STILL)
                    begin
                        vert_nudge_next = NUDGE_NEG;
                        vert_time_next  = item.now_ms;
                        batch.count     = 2'd1;
                        batch.first.dy  = $signed(p1_neg);
                    end
                end
                OPT_NUDGE_DOWN:
                begin
                    if (vert_nudge_reg == NUDGE_NEG)
                        vert_nudge_next = NUDGE_STILL;
                    else if (vert_nudge_reg == NUDGE_STILL)
                    begin
                        vert_nudge_next = NUDGE_POS;
                        vert_time_next  = item.now_ms;
                        batch.count     = 2'd1;
                        batch.first.dy  = $signed(p1_pos);
                    end
                end
                OPT_NUDGE_LEFT:
                begin
                    if (horz_nudge_reg == NUDGE_POS)
                        horz_nudge_next = NUDGE_STILL;
                    else if (horz_nudge_reg == NUDGE_STILL)
                    begin
                        horz_nudge_next = NUDGE_NEG;
                        horz_time_next  = item.now_ms;
                        batch.count     = 2'd1;
                        batch.first.dx  = $signed(p1_neg);
                    end
                end
                OPT_NUDGE_RIGHT:
                begin
                    if (horz_nudge_reg == NUDGE_NEG)
                        horz_nudge_next = NUDGE_STILL;
                    else if (horz_nudge_reg == NUDGE_STILL)
                    begin
                        horz_nudge_next = NUDGE_POS;
                        horz_time_next  = item.now_ms;
                        batch.count     = 2'd1;
                        batch.first.dx  = $signed(p1_pos);
                    end
                end
                OPT_NUDGE_STOP:
                begin
                    vert_nudge_next = NUDGE_STILL;
                    horz_nudge_next = NUDGE_STILL;
                end
                default:
                begin
                end
            endcase
        end
        else if (item.cmd == CMD_ACTION)
        begin
            // held repeat, dropped when the axis interval has not run out
            top_speed_next = ev_top;
            case (item.option) inside
                OPT_UP, OPT_DOWN:
                begin
                    if (vert_ok)
                    begin
                        vert_time_next = item.now_ms;
                        batch.count    = 2'd1;
                        batch.first.dy = (item.option == OPT_UP) ?
                                         $signed(ev_neg) : $signed(ev_pos);
                    end
                end
                OPT_LEFT, OPT_RIGHT:
                begin
                    if (horz_ok)
                    begin
                        horz_time_next = item.now_ms;
                        batch.count    = 2'd1;
                        batch.first.dx = (item.option == OPT_LEFT) ?
                                         $signed(ev_neg) : $signed(ev_pos);
                    end
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            // tick: vertical first, then horizontal
            if (v_act || h_act)
                top_speed_next = ev_top;
            if (v_emit)
                vert_time_next = item.now_ms;
            if (h_emit)
                horz_time_next = item.now_ms;
            if (v_emit)
            begin
                batch.first  = v_res;
                batch.second = h_res;
                batch.count  = h_emit ? 2'd2 : 2'd1;
            end
            else if (h_emit)
            begin
                batch.first = h_res;
                batch.count = 2'd1;
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_start_reg <= '0;
            vert_time_reg   <= '0;
            horz_time_reg   <= '0;
            top_speed_reg   <= 1'b0;
            vert_nudge_reg  <= NUDGE_STILL;
            horz_nudge_reg  <= NUDGE_STILL;
        end
        else if (fire)
        begin
            press_start_reg <= press_start_next;
            vert_time_reg   <= vert_time_next;
            horz_time_reg   <= horz_time_next;
            top_speed_reg   <= top_speed_next;
            vert_nudge_reg  <= vert_nudge_next;
            horz_nudge_reg  <= horz_nudge_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/accelerating_pointer_repeat.sv @@
// channel   dir  handshake          contents
// s_*       in   s_tvalid/s_tready  request: cmd, option, repeat_flag, now_ms
// m_*       out  m_tvalid/m_tready  result: kind, dx, dy, last
// apb       in   psel/penable       eight speed-phase registers, 4-byte stride
//
// a request waits in the input register until the output buffer is free, then the decode logic
// writes its results into a two-slot output buffer and updates the state
// one result per cycle leaves the buffer while m_tready is high, so a tick with two moves
// sends them one after the other and single-result requests flow at one per cycle
// the input register refills while the buffer still holds a waiting result
// rst_n clears state, nudges and buffer and loads the register defaults
`default_nettype none

module accelerating_pointer_repeat
    import apr_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // request stream
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,  // option[3:0], repeat_flag[4], now_ms[20:5]
    input  wire logic                s_tuser,  // cmd
    // result stream
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,  // dx[8:0], dy[17:9]
    output logic [2:0]               m_tuser,  // kind
    output logic                     m_tlast,
    // register port
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

`include "accelerating_pointer_repeat_assert.svh"

    apr_cfg_t    cfg_reg;
    apr_item_t   item_reg;
    logic        in_valid_reg, in_valid_next;
    apr_result_t first_reg, second_reg;
    logic [1:0]  cnt_reg, cnt_next;
    apr_batch_t  batch;

    logic        s_fire;
    logic        m_fire;
    logic        out_free;
    logic        process;
    logic        cfg_write;
    logic [2:0]  reg_index;

    // handshakes
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = m_tvalid && m_tready;
    assign out_free = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_fire);
    assign process  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || process;

    // register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase1_delay <= PHASE1_DELAY_RST;
            cfg_reg.phase1_step  <= PHASE1_STEP_RST;
            cfg_reg.phase1_end   <= PHASE1_END_RST;
            cfg_reg.phase2_delay <= PHASE2_DELAY_RST;
            cfg_reg.phase2_step  <= PHASE2_STEP_RST;
            cfg_reg.phase2_end   <= PHASE2_END_RST;
            cfg_reg.phase3_delay <= PHASE3_DELAY_RST;
            cfg_reg.phase3_step  <= PHASE3_STEP_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                REG_PHASE1_DELAY: cfg_reg.phase1_delay <= pwdata[7:0];
                REG_PHASE1_STEP:  cfg_reg.phase1_step  <= pwdata[7:0];
                REG_PHASE1_END:   cfg_reg.phase1_end   <= pwdata[15:0];
                REG_PHASE2_DELAY: cfg_reg.phase2_delay <= pwdata[7:0];
                REG_PHASE2_STEP:  cfg_reg.phase2_step  <= pwdata[7:0];
                REG_PHASE2_END:   cfg_reg.phase2_end   <= pwdata[15:0];
                REG_PHASE3_DELAY: cfg_reg.phase3_delay <= pwdata[7:0];
                REG_PHASE3_STEP:  cfg_reg.phase3_step  <= pwdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // register read-back
    always_comb
    begin
        unique case (reg_index)
            REG_PHASE1_DELAY: prdata = {24'd0, cfg_reg.phase1_delay};
            REG_PHASE1_STEP:  prdata = {24'd0, cfg_reg.phase1_step};
            REG_PHASE1_END:   prdata = {16'd0, cfg_reg.phase1_end};
            REG_PHASE2_DELAY: prdata = {24'd0, cfg_reg.phase2_delay};
            REG_PHASE2_STEP:  prdata = {24'd0, cfg_reg.phase2_step};
            REG_PHASE2_END:   prdata = {16'd0, cfg_reg.phase2_end};
            REG_PHASE3_DELAY: prdata = {24'd0, cfg_reg.phase3_delay};
            REG_PHASE3_STEP:  prdata = {24'd0, cfg_reg.phase3_step};
            default:          prdata = '0;
        endcase
    end

    // input register
    always_comb
    begin
        if (s_fire)
            in_valid_next = 1'b1;
        else if (process)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            item_reg.cmd         <= s_tuser;
            item_reg.option      <= s_tdata[3:0];
            item_reg.repeat_flag <= s_tdata[4];
            item_reg.now_ms      <= s_tdata[20:5];
        end
    end

    // decode and state
    apr_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .fire  (process),
        .item  (item_reg),
        .batch (batch)
    );

    // output buffer: load a batch or shift after a taken result
    always_comb
    begin
        if (process)
            cnt_next = batch.count;
        else if (m_fire)
            cnt_next = cnt_reg - 2'd1;
        else
            cnt_next = cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            cnt_reg      <= 2'd0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            first_reg  <= batch.first;
            second_reg <= batch.second;
        end
        else if (m_fire)
        begin
            first_reg <= second_reg;
        end
    end

    // result stream
    assign m_tvalid = cnt_reg != 2'd0;
    assign m_tlast  = cnt_reg == 2'd1;
    assign m_tuser  = first_reg.kind;
    assign m_tdata  = {{(M_DATA_W - 18){1'b0}}, first_reg.dy, first_reg.dx};

    // checks
    `APR_ASSERT_HOLDS(a_cnt_range, cnt_reg != 2'd3, "output buffer count out of range")
    `APR_ASSERT_IMP(a_pair_not_last, cnt_reg == 2'd2, !m_tlast, "first of two marked last")
    `APR_ASSERT_NEXT(a_load_count, process, cnt_reg == $past(batch.count),
        "buffer count differs from decoded batch")
    `APR_ASSERT_NEXT(a_drain_pair, m_fire && (cnt_reg == 2'd2), cnt_reg == 2'd1,
        "buffer refilled while a result was pending")

endmodule

`default_nettype wire
